/* hw/rtl/sorted_array_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for sorted_array_priority_queue
// Clocked, reset-qualified concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset.
`define SAQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Antecedent at one edge implies consequent at the next edge.
`define SAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SAQ_ASSERT(lbl, cond, msg)
`define SAQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/saq_pkg.sv */
// ----------------------------------------------------------------------------
// saq_pkg
// Shared widths, codes and cell link types of the sorted priority queue.
// ----------------------------------------------------------------------------
package saq_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned CountW       = 5;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } status_e;

  // Broadcast to every cell for one operation; the item value goes on its own
  // wire so the match logic does not loop back through these strobes.
  typedef struct packed {
    logic ins;
    logic del;
    logic clr;
  } ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                    p;      // new value belongs here or below
    logic                    ge;     // entry >= value (delete shift point)
    logic                    valid;
    logic signed [DataW-1:0] entry;
  } link_t;

endpackage

/* hw/rtl/saq_cell.sv */
// ----------------------------------------------------------------------------
// saq_cell
// One slot of the sorted chain: holds an entry, shifts up or down on demand.
// ----------------------------------------------------------------------------
module saq_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  saq_pkg::ctrl_t                   ctrl_i,
  input  logic signed [saq_pkg::DataW-1:0] value_i,
  input  saq_pkg::link_t                   lo_i,    // neighbor one place down
  input  saq_pkg::link_t                   hi_i,    // neighbor one place up
  output saq_pkg::link_t                   link_o,
  output logic                             hit_o
);

  logic signed [saq_pkg::DataW-1:0] entry_q, entry_d;
  logic                             valid_q, valid_d;
  logic                             less, p, ge;

  assign less = valid_q && (value_i < entry_q);
  assign p    = less || !valid_q;
  assign ge   = valid_q && !(entry_q < value_i);

  // first entry >= value, and equal to it
  assign hit_o = ge && !lo_i.ge && (entry_q == value_i);

  assign link_o = '{p: p, ge: ge, valid: valid_q, entry: entry_q};

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.ins) begin
      if (lo_i.p) begin
        entry_d = lo_i.entry;
      end else if (p) begin
        entry_d = value_i;
      end
      valid_d = valid_q || lo_i.valid;
    end else if (ctrl_i.del && ge) begin
      entry_d = hi_i.entry;
      valid_d = hi_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* hw/rtl/sorted_array_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Result: registered, and valid in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; all cells update
// from neighbors in the same cycle; the result register frees as it is taken.
// Reset: asynchronous, active low; queue empty, no result pending. Entry
// storage is not cleared, only the per-cell valid bits.
// ----------------------------------------------------------------------------
`include "sorted_array_priority_queue_assert.svh"

module sorted_array_priority_queue #(
  parameter int unsigned DEPTH = saq_pkg::DefaultDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [saq_pkg::CmdW-1:0]           command_i,
  input  logic signed [saq_pkg::DataW-1:0]   value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [saq_pkg::StatusW-1:0]        status_o,
  output logic [saq_pkg::CountW-1:0]         count_o,
  output logic signed [saq_pkg::DataW-1:0]   head_value_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Chain of cells, cell 0 holds the smallest entry.
  saq_pkg::ctrl_t            ctrl;
  saq_pkg::link_t            link [DEPTH];
  logic [DEPTH-1:0]          hit_vec;
  logic [DEPTH-1:0]          valid_vec;

  logic                      accept;
  logic                      full, empty, hit;
  logic [CntW-1:0]           count_q, count_d;
  saq_pkg::status_e          status_q, status_d;
  logic                      out_valid_q;

  // The queue state always matches the pending result: a new item is only
  // taken when the result slot is empty or is being drained this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = link[DEPTH-1].valid;
  assign empty = !link[0].valid;
  assign hit   = |hit_vec;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    saq_pkg::link_t lo, hi;

    if (k == 0) begin : g_bottom
      // Below cell 0 sits an always-valid, never-greater slot.
      assign lo = '{p: 1'b0, ge: 1'b0, valid: 1'b1, entry: value_i};
    end else begin : g_lo
      assign lo = link[k-1];
    end

    if (k == DEPTH - 1) begin : g_top
      assign hi = '{p: 1'b1, ge: 1'b0, valid: 1'b0, entry: link[k].entry};
    end else begin : g_hi
      assign hi = link[k+1];
    end

    saq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .value_i (value_i),
      .lo_i    (lo),
      .hi_i    (hi),
      .link_o  (link[k]),
      .hit_o   (hit_vec[k])
    );

    assign valid_vec[k] = link[k].valid;
  end

  // Command decode: what the cells do and what the item reports.
  always_comb begin
    ctrl       = '{ins: 1'b0, del: 1'b0, clr: 1'b0};
    status_d   = saq_pkg::ST_OK;
    count_d    = count_q;
    if (accept) begin
      unique case (command_i)
        saq_pkg::CMD_INSERT: begin
          if (full) begin
            status_d = saq_pkg::ST_OVERFLOW;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end
        saq_pkg::CMD_DELETE: begin
          if (empty) begin
            status_d = saq_pkg::ST_UNDERFLOW;
          end else if (!hit) begin
            status_d = saq_pkg::ST_NOTFOUND;
          end else begin
            ctrl.del = 1'b1;
            count_d  = count_q - CntW'(1);
          end
        end
        saq_pkg::CMD_CLEAR: begin
          ctrl.clr = 1'b1;
          count_d  = '0;
        end
        default: ;  // unused code: queue unchanged, status ok
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= saq_pkg::ST_OK;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign count_o      = saq_pkg::CountW'(count_q);
  assign head_value_o = link[0].valid ? link[0].entry : '0;

  // Count tracks the cells that hold an entry.
  `SAQ_ASSERT(a_count_matches_cells, count_q == CntW'($countones(valid_vec)), "count mismatch")
  // Occupied cells form one run starting at cell 0.
  `SAQ_ASSERT(a_cells_packed, (valid_vec & (valid_vec + DEPTH'(1))) == '0, "gap in cell chain")
  // Insert into a full queue reports overflow and leaves the count alone.
  `SAQ_ASSERT_NEXT(a_overflow, accept && command_i == saq_pkg::CMD_INSERT && full, status_o == saq_pkg::ST_OVERFLOW && $stable(count_q), "overflow not flagged")
  // A successful delete always shrinks the queue by one.
  `SAQ_ASSERT_NEXT(a_delete_shrinks, ctrl.del, count_q == $past(count_q) - CntW'(1) && status_o == saq_pkg::ST_OK, "delete count wrong")

endmodule
